// File: rtl/lwjf_pkg.sv
// Package for the line weight and junk filter: beat types, phase and verdict codes,
// and the character class helpers. No dependencies.
package lwjf_pkg;

	localparam int MAX_LINE_DEF = 1024;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTED_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_JUNK_FILTER   = 1'd1;

	// prefix scan phases
	localparam logic [1:0] PH_SCAN     = 2'd0;
	localparam logic [1:0] PH_PLAIN    = 2'd1;
	localparam logic [1:0] PH_PREFIXED = 2'd2;

	// verdict codes
	localparam logic [2:0] VC_OK      = 3'd0;
	localparam logic [2:0] VC_LENGTH  = 3'd1;
	localparam logic [2:0] VC_JSON    = 3'd2;
	localparam logic [2:0] VC_TAG     = 3'd3;
	localparam logic [2:0] VC_HEXHASH = 3'd4;
	localparam logic [2:0] VC_BASE64  = 3'd5;
	localparam logic [2:0] VC_HEXWRAP = 3'd6;

	localparam logic [2:0] HEXWRAP_LEN = 3'd5;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       end_of_line;
	} line_beat_t;

	typedef struct packed {
		logic        keep_line;
		logic [2:0]  verdict_code;
		logic [31:0] line_weight;
		logic [10:0] payload_offset;
		logic [10:0] payload_length;
	} verdict_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	endfunction

	function automatic logic is_b64(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || (c == "+") || (c == "/") || (c == "=");
	endfunction

	// "$HEX[" by position
	function automatic logic [7:0] hexwrap_char(input logic [2:0] q);
		logic [7:0] c;
		unique case (q)
			3'd0: c = "$";
			3'd1: c = "H";
			3'd2: c = "E";
			3'd3: c = "X";
			3'd4: c = "[";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/lwjf_line_state.sv
// Per-line scan state of the line weight and junk filter and the verdict logic.
// Depends on lwjf_pkg.
module lwjf_line_state #(
	parameter int MAX_LINE = lwjf_pkg::MAX_LINE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  lwjf_pkg::line_beat_t beat,
	input  logic                 weighted_mode,
	input  logic                 junk_filter_enable,
	output lwjf_pkg::verdict_t   verdict
);

	localparam int CW = $clog2(MAX_LINE + 1);
	localparam logic [CW-1:0] CNT_MAX   = CW'(MAX_LINE);
	localparam logic [CW-1:0] LEN_LIMIT = CW'(MAX_LINE - 64);

	logic [CW-1:0] byte_count_q, payload_start_q;
	logic [1:0]    phase_q;
	logic [31:0]   accum_q;
	logic [15:0]   first_two_q, last_two_q;
	logic          hex_only_q, b64_only_q;
	logic [2:0]    hexwrap_q;

	logic [CW-1:0] pos, cnt_n, ps_n, diff, plen;
	logic [1:0]    phase_n;
	logic [31:0]   accum_n;
	logic [35:0]   accum_x10;
	logic [15:0]   first_two_n, last_two_n;
	logic          hex_only_n, b64_only_n;
	logic [2:0]    hexwrap_n, q3;
	logic          to_payload, clear_pl, q_ok, q_is0, q_is1, q_lt5;
	logic [7:0]    b, c0, c1, l0, l1;
	logic [2:0]    code;
	logic [CW+10:0] ps_ext, plen_ext;

	assign b   = beat.line_byte;
	assign pos = byte_count_q;
	assign accum_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0}
		+ {32'd0, b[3:0] - 4'd0};

	always_comb begin
		cnt_n      = (pos < CNT_MAX) ? pos + CW'(1) : pos;
		phase_n    = phase_q;
		accum_n    = accum_q;
		ps_n       = payload_start_q;
		to_payload = 1'b1;
		clear_pl   = 1'b0;
		if (phase_q == lwjf_pkg::PH_SCAN) begin
			priority if (weighted_mode && lwjf_pkg::is_digit(b)) begin
				// b - '0' is the low nibble for digits
				accum_n = (accum_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : accum_x10[31:0];
			end else if (weighted_mode && (b == ":") && (pos != '0)) begin
				phase_n    = lwjf_pkg::PH_PREFIXED;
				ps_n       = cnt_n;
				clear_pl   = 1'b1;
				to_payload = 1'b0;
			end else begin
				phase_n = lwjf_pkg::PH_PLAIN;
			end
		end
	end

	// payload position of this byte, zero if it falls before the payload start
	always_comb begin
		diff  = pos - payload_start_q;
		q_ok  = pos >= payload_start_q;
		q_is0 = !q_ok || (diff == '0);
		q_is1 = q_ok && (diff == CW'(1));
		q_lt5 = !q_ok || (diff < CW'(5));
		q3    = q_ok ? diff[2:0] : 3'd0;
	end

	always_comb begin
		if (clear_pl) begin
			first_two_n = '0;
			last_two_n  = '0;
			hex_only_n  = 1'b1;
			b64_only_n  = 1'b1;
			hexwrap_n   = '0;
		end else begin
			first_two_n = first_two_q;
			last_two_n  = last_two_q;
			hex_only_n  = hex_only_q;
			b64_only_n  = b64_only_q;
			hexwrap_n   = hexwrap_q;
		end
		if (to_payload) begin
			if (q_is0) first_two_n[15:8] = b;
			else if (q_is1) first_two_n[7:0] = b;
			last_two_n = {last_two_q[7:0], b};
			if (!lwjf_pkg::is_hex(b)) hex_only_n = 1'b0;
			if (!lwjf_pkg::is_b64(b)) b64_only_n = 1'b0;
			if (q_lt5 && (hexwrap_q == q3) && (b == lwjf_pkg::hexwrap_char(q3)))
				hexwrap_n = q3 + 3'd1;
		end
	end

	// verdict on the state that includes this byte
	always_comb begin
		plen = cnt_n - ps_n;
		c0   = first_two_n[15:8];
		c1   = first_two_n[7:0];
		l0   = last_two_n[7:0];
		l1   = last_two_n[15:8];
		code = lwjf_pkg::VC_OK;
		priority if (cnt_n >= LEN_LIMIT) begin
			code = lwjf_pkg::VC_LENGTH;
		end else if ((plen >= CW'(5)) && (hexwrap_n == lwjf_pkg::HEXWRAP_LEN)) begin
			code = lwjf_pkg::VC_HEXWRAP;
		end else if (plen == '0) begin
			code = lwjf_pkg::VC_LENGTH;
		end else if (junk_filter_enable && (plen >= CW'(4))) begin
			priority if ((c0 == "{") || (c0 == "[")) begin
				code = lwjf_pkg::VC_JSON;
			end else if ((c0 == "<") && (lwjf_pkg::is_alpha(c1) || (c1 == "/")
					|| (c1 == "!"))) begin
				code = lwjf_pkg::VC_TAG;
			end else if ((plen >= CW'(32)) && hex_only_n) begin
				code = lwjf_pkg::VC_HEXHASH;
			end else if ((plen >= CW'(40)) && b64_only_n && ((l0 == "=") || (l1 == "="))) begin
				code = lwjf_pkg::VC_BASE64;
			end else begin
				code = lwjf_pkg::VC_OK;
			end
		end else begin
			code = lwjf_pkg::VC_OK;
		end
		ps_ext   = {11'd0, ps_n};
		plen_ext = {11'd0, plen};
		verdict.keep_line      = (code == lwjf_pkg::VC_OK);
		verdict.verdict_code   = code;
		verdict.line_weight    = ((phase_n == lwjf_pkg::PH_PREFIXED) && (accum_n != '0))
			? accum_n : 32'd1;
		verdict.payload_offset = ps_ext[10:0];
		verdict.payload_length = plen_ext[10:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			phase_q         <= lwjf_pkg::PH_SCAN;
			accum_q         <= '0;
			payload_start_q <= '0;
			first_two_q     <= '0;
			last_two_q      <= '0;
			hex_only_q      <= 1'b1;
			b64_only_q      <= 1'b1;
			hexwrap_q       <= '0;
		end else if (advance) begin
			if (beat.end_of_line) begin
				byte_count_q    <= '0;
				phase_q         <= lwjf_pkg::PH_SCAN;
				accum_q         <= '0;
				payload_start_q <= '0;
				first_two_q     <= '0;
				last_two_q      <= '0;
				hex_only_q      <= 1'b1;
				b64_only_q      <= 1'b1;
				hexwrap_q       <= '0;
			end else begin
				byte_count_q    <= cnt_n;
				phase_q         <= phase_n;
				accum_q         <= accum_n;
				payload_start_q <= ps_n;
				first_two_q     <= first_two_n;
				last_two_q      <= last_two_n;
				hex_only_q      <= hex_only_n;
				b64_only_q      <= b64_only_n;
				hexwrap_q       <= hexwrap_n;
			end
		end
	end

endmodule

// File: rtl/line_weight_and_junk_filter.sv
// Top level of the line weight and junk filter: input register, configuration
// registers and verdict register. Depends on lwjf_pkg and lwjf_line_state.
//
// The block takes a text line one byte per beat and returns one verdict beat
// for each line, on the beat marked end_of_line. It sustains one byte per cycle
// while no end-of-line byte is held up: every accepted byte waits in the input
// register and is folded into the line state when it advances; on the last byte
// of a line the verdict is written to the verdict register as that byte advances,
// so a verdict passes the input register and then the verdict register. The only
// back pressure is the verdict register: while it holds an untaken verdict, a
// further end-of-line byte waits in the input register and the line side sees
// stall. Ordinary bytes keep flowing past a waiting verdict. In weighted mode
// a "digits:" prefix is stripped and reported as line_weight (1 when absent or
// zero, saturating at all ones); weighted_mode is looked at on every byte of
// the digit scan, and junk_filter_enable on the last byte. Write the
// configuration only while the block is idle.
module line_weight_and_junk_filter #(
	parameter int MAX_LINE = lwjf_pkg::MAX_LINE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// line bytes
	input  logic                                 line_valid,
	output logic                                 line_stall,
	input  lwjf_pkg::line_beat_t                 line,
	// verdicts
	output logic                                 verdict_valid,
	input  logic                                 verdict_stall,
	output lwjf_pkg::verdict_t                   verdict,
	// configuration
	input  logic                                 cfg_we,
	input  logic [lwjf_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [lwjf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                 weighted_mode_q, junk_filter_q;
	logic                 valid_s1;
	lwjf_pkg::line_beat_t beat_s1;
	logic                 out_free, advance, accept;
	lwjf_pkg::verdict_t   verdict_d;
	lwjf_pkg::verdict_t   verdict_q;
	logic                 verdict_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_mode_q <= 1'b0;
			junk_filter_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lwjf_pkg::REG_WEIGHTED_MODE: weighted_mode_q <= cfg_data[0];
				lwjf_pkg::REG_JUNK_FILTER:   junk_filter_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the verdict register frees up this cycle if empty or being taken
	assign out_free   = !verdict_valid_q || !verdict_stall;
	// an end-of-line byte needs a free verdict register; other bytes always go
	assign advance    = valid_s1 && (!beat_s1.end_of_line || out_free);
	assign line_stall = valid_s1 && !advance;
	assign accept     = line_valid && !line_stall;

	// input register: load a new beat, or drop the one that advanced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) beat_s1 <= line;
	end

	lwjf_line_state #(
		.MAX_LINE (MAX_LINE)
	) u_line_state (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (advance),
		.beat               (beat_s1),
		.weighted_mode      (weighted_mode_q),
		.junk_filter_enable (junk_filter_q),
		.verdict            (verdict_d)
	);

	wire load_verdict = advance && beat_s1.end_of_line;

	// verdict register: hold while stalled, load at the end of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (load_verdict) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_verdict) verdict_q <= verdict_d;
	end

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

endmodule

// File: rtl/lwjf_checker.sv
// Port-level checks on the verdict channel of the line weight and junk filter,
// bound to the top level. Depends on lwjf_pkg and line_weight_and_junk_filter.
module lwjf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               verdict_valid,
	input logic               verdict_stall,
	input lwjf_pkg::verdict_t verdict
);

	// a stalled verdict beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
		else $error("verdict beat changed while stalled");

	// keep flag agrees with the code
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.keep_line == (verdict.verdict_code == lwjf_pkg::VC_OK)))
		else $error("keep_line disagrees with verdict_code");

	// weight is never reported as zero
	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.line_weight != 32'd0))
		else $error("zero line weight");

	// only defined verdict codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.verdict_code <= lwjf_pkg::VC_HEXWRAP))
		else $error("undefined verdict code");

endmodule

bind line_weight_and_junk_filter lwjf_checker u_lwjf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict)
);

// File: tb/line_weight_and_junk_filter_test.sv
// Self-checking testbench for line_weight_and_junk_filter: directed lines, long lines and
// a random line mix under changing register settings and handshake idling.
// Depends on lwjf_pkg and the line_weight_and_junk_filter RTL.
module line_weight_and_junk_filter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_CAP      = lwjf_pkg::MAX_LINE_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int MIX_BYTES     = 20;
	// register settings of the six random phases, bit n for phase n
	localparam bit [5:0] MIX_WEIGHTED = 6'b010101;
	localparam bit [5:0] MIX_JUNK     = 6'b010011;

	localparam string DIGIT_SET  = "0123456789";
	localparam string HEX_SET    = "0123456789abcdefABCDEF";
	localparam string LETTER_SET = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
	localparam string B64_SET    =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam string WRAP_TEXT  = "$HEX[";

	logic                             clk;
	logic                             arst_n        = 1'b0;
	logic                             line_valid    = 1'b0;
	logic                             line_stall;
	lwjf_pkg::line_beat_t             line          = '0;
	logic                             verdict_valid;
	logic                             verdict_stall = 1'b0;
	lwjf_pkg::verdict_t               verdict;
	logic                             cfg_we        = 1'b0;
	logic [lwjf_pkg::CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [lwjf_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

	line_weight_and_junk_filter dut (
		.clk, .arst_n,
		.line_valid, .line_stall, .line,
		.verdict_valid, .verdict_stall, .verdict,
		.cfg_we, .cfg_index, .cfg_data
	);

	// Shadow of the register file and of the per-line scan state.
	logic        weighted_on;
	logic        junk_on;
	logic [10:0] line_len;
	logic [1:0]  scan_phase;
	logic [31:0] weight_sum;
	logic [10:0] body_start;
	logic [15:0] head_chars;   // first payload byte in [15:8], second in [7:0]
	logic [15:0] tail_chars;   // last payload byte in [7:0]
	logic        all_hex;
	logic        all_b64;
	logic [2:0]  wrap_seen;    // how much of "$HEX[" the payload has matched so far

	lwjf_pkg::verdict_t verdicts_due[$];
	logic [7:0]  text_buf[$];
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          bytes_sent    = 0;
	int          verdicts_seen = 0;
	int          errors        = 0;
	int          cycles        = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Stall the verdict side at random; one assignment per falling edge.
	always @(negedge clk) begin
		verdict_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Compare every accepted verdict beat against the oldest prediction.
	always @(posedge clk) begin
		lwjf_pkg::verdict_t want;
		if (arst_n && verdict_valid && !verdict_stall) begin
			verdicts_seen <= verdicts_seen + 1;
			if (verdicts_due.size() == 0) begin
				$error("verdict beat arrived with no line pending");
				errors = errors + 1;
			end else begin
				want = verdicts_due.pop_front();
				if (verdict.keep_line !== want.keep_line) begin
					$error("keep_line: expected %0d, got %0d", want.keep_line, verdict.keep_line);
					errors = errors + 1;
				end
				if (verdict.verdict_code !== want.verdict_code) begin
					$error("verdict_code: expected %0d, got %0d",
						want.verdict_code, verdict.verdict_code);
					errors = errors + 1;
				end
				if (verdict.line_weight !== want.line_weight) begin
					$error("line_weight: expected %0d, got %0d",
						want.line_weight, verdict.line_weight);
					errors = errors + 1;
				end
				if (verdict.payload_offset !== want.payload_offset) begin
					$error("payload_offset: expected %0d, got %0d",
						want.payload_offset, verdict.payload_offset);
					errors = errors + 1;
				end
				if (verdict.payload_length !== want.payload_length) begin
					$error("payload_length: expected %0d, got %0d",
						want.payload_length, verdict.payload_length);
					errors = errors + 1;
				end
			end
		end
	end

	function automatic logic is_dec(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_hexch(input logic [7:0] c);
		return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_b64ch(input logic [7:0] c);
		return is_letter(c) || is_dec(c) || c == "+" || c == "/" || c == "=";
	endfunction

	task automatic clear_body();
		head_chars = '0;
		tail_chars = '0;
		all_hex    = 1'b1;
		all_b64    = 1'b1;
		wrap_seen  = '0;
	endtask

	task automatic clear_line();
		line_len   = '0;
		scan_phase = lwjf_pkg::PH_SCAN;
		weight_sum = '0;
		body_start = '0;
		clear_body();
	endtask

	// Fold one accepted byte into the shadow state; on the last byte of a
	// line, queue the verdict the block owes and start a fresh line.
	task automatic fold_byte(input logic [7:0] b, input logic eol);
		logic [10:0] pos;
		logic [10:0] plen;
		logic [10:0] q;
		logic [63:0] wide;
		logic [2:0]  code;
		logic        feed;
		lwjf_pkg::verdict_t v;
		pos  = line_len;
		feed = 1'b1;
		if (line_len < LINE_CAP)
			line_len = line_len + 11'd1;
		if (scan_phase == lwjf_pkg::PH_SCAN) begin
			if (weighted_on && is_dec(b)) begin
				wide = 64'(weight_sum) * 64'd10 + 64'(b - "0");
				weight_sum = (wide > 64'hFFFF_FFFF) ? '1 : wide[31:0];
			end else if (weighted_on && b == ":" && pos != 0) begin
				// drop the prefix: the payload starts after the colon
				scan_phase = lwjf_pkg::PH_PREFIXED;
				body_start = line_len;
				clear_body();
				feed = 1'b0;
			end else begin
				scan_phase = lwjf_pkg::PH_PLAIN;
			end
		end
		if (feed) begin
			q = (pos >= body_start) ? pos - body_start : '0;
			if (q == 0)
				head_chars[15:8] = b;
			else if (q == 1)
				head_chars[7:0] = b;
			tail_chars = {tail_chars[7:0], b};
			all_hex    = all_hex & is_hexch(b);
			all_b64    = all_b64 & is_b64ch(b);
			if (q < 5 && wrap_seen == q && b == WRAP_TEXT[q])
				wrap_seen = wrap_seen + 3'd1;
		end
		if (eol) begin
			plen = line_len - body_start;
			code = lwjf_pkg::VC_OK;
			// length wins over everything, then the hex wrapper, then an empty payload
			if (line_len >= LINE_CAP - 64)
				code = lwjf_pkg::VC_LENGTH;
			else if (plen >= 5 && wrap_seen == lwjf_pkg::HEXWRAP_LEN)
				code = lwjf_pkg::VC_HEXWRAP;
			else if (plen == 0)
				code = lwjf_pkg::VC_LENGTH;
			else if (junk_on && plen >= 4) begin
				if (head_chars[15:8] == "{" || head_chars[15:8] == "[")
					code = lwjf_pkg::VC_JSON;
				else if (head_chars[15:8] == "<" && (is_letter(head_chars[7:0]) ||
						head_chars[7:0] == "/" || head_chars[7:0] == "!"))
					code = lwjf_pkg::VC_TAG;
				else if (plen >= 32 && all_hex)
					code = lwjf_pkg::VC_HEXHASH;
				else if (plen >= 40 && all_b64 &&
						(tail_chars[7:0] == "=" || tail_chars[15:8] == "="))
					code = lwjf_pkg::VC_BASE64;
			end
			v.keep_line      = (code == lwjf_pkg::VC_OK);
			v.verdict_code   = code;
			v.line_weight    = (scan_phase == lwjf_pkg::PH_PREFIXED && weight_sum != 0) ?
				weight_sum : 32'd1;
			v.payload_offset = body_start;
			v.payload_length = plen;
			verdicts_due.push_back(v);
			clear_line();
		end
	endtask

	// Drive one line beat, with random idle cycles ahead of it, and hold it
	// until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic eol);
		lwjf_pkg::line_beat_t beat;
		beat = '{line_byte: b, end_of_line: eol};
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			line_valid <= 1'b0;
			@(negedge clk);
		end
		line_valid <= 1'b1;
		line       <= beat;
		@(posedge clk);
		while (line_stall)
			@(posedge clk);
		bytes_sent = bytes_sent + 1;
		fold_byte(b, eol);
	endtask

	task automatic send_buf();
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic send_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		send_buf();
	endtask

	// Drop valid, let every owed verdict come back, then let the block settle
	// so it can fold any trailing byte before registers are touched.
	task automatic finish_lines();
		@(negedge clk);
		line_valid <= 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [lwjf_pkg::CFG_INDEX_W-1:0] idx, input logic val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		if (idx == lwjf_pkg::REG_WEIGHTED_MODE)
			weighted_on = val;
		else
			junk_on = val;
	endtask

	// 0: sender idles lightly, receiver heavily; 1: the reverse; else no idling.
	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 24;
				recv_idle_pct = 72;
			end
			1: begin
				send_idle_pct = 72;
				recv_idle_pct = 24;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	function automatic logic [7:0] pick(input string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	task automatic add_from(input string set, input int n);
		repeat (n) text_buf.push_back(pick(set));
	endtask

	task automatic add_printable(input int n);
		repeat (n) text_buf.push_back(8'($urandom_range(32, 126)));
	endtask

	task automatic add_noise(input int n);
		repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// Build one random line: an optional count prefix, then a payload aimed
	// at one of the verdicts, sometimes broken so it just misses.
	task automatic build_random_line();
		int pre;
		int n;
		int body_at;
		text_buf.delete();
		pre = $urandom_range(0, 9);
		if (pre < 4) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 3);
			if (pre == 0)
				repeat (n) text_buf.push_back("0");
			else
				add_from(DIGIT_SET, n);
			text_buf.push_back(":");
		end
		body_at = text_buf.size();
		case ($urandom_range(0, 9))
			0: add_printable($urandom_range(0, 12));
			1: begin
				text_buf.push_back(pick("{["));
				add_printable($urandom_range(0, 8));
			end
			2: begin
				text_buf.push_back("<");
				case ($urandom_range(0, 3))
					0: text_buf.push_back(pick(LETTER_SET));
					1: text_buf.push_back("/");
					2: text_buf.push_back("!");
					default: add_noise(1);
				endcase
				add_printable($urandom_range(0, 6));
			end
			3: begin
				add_from(HEX_SET, $urandom_range(28, 40));
				if ($urandom_range(0, 4) == 0)
					text_buf[$urandom_range(body_at, text_buf.size() - 1)] = pick("gz-. ");
			end
			4: begin
				add_from(B64_SET, $urandom_range(36, 46));
				case ($urandom_range(0, 3))
					0: text_buf.push_back("=");
					1: begin
						text_buf.push_back("=");
						text_buf.push_back("=");
					end
					2: begin
						text_buf.push_back("=");
						text_buf.push_back(pick(B64_SET));
					end
					default: ;
				endcase
				if ($urandom_range(0, 4) == 0)
					text_buf[$urandom_range(body_at, text_buf.size() - 1)] = pick("-.:#");
			end
			5: begin
				for (int i = 0; i < WRAP_TEXT.len(); i++)
					text_buf.push_back(WRAP_TEXT[i]);
				if ($urandom_range(0, 5) == 0)
					text_buf[body_at + $urandom_range(0, 4)] = 8'($urandom_range(32, 126));
				add_from(HEX_SET, $urandom_range(0, 8));
				if ($urandom_range(0, 1) == 1)
					text_buf.push_back("]");
			end
			6: add_from(DIGIT_SET, $urandom_range(1, 10));
			7: add_noise($urandom_range(1, 10));
			8: begin
				text_buf.push_back(":");
				add_printable($urandom_range(0, 6));
			end
			default: begin
				// digits broken by a letter before the colon: no prefix
				add_from(DIGIT_SET, $urandom_range(1, 3));
				text_buf.push_back(pick(LETTER_SET));
				text_buf.push_back(":");
				add_printable($urandom_range(0, 4));
			end
		endcase
		if (text_buf.size() == 0)
			add_printable(1);
	endtask

	// Both registers still at reset: no prefix stripping, no junk checks.
	task automatic test_reset_settings();
		set_idling(0);
		send_text("12:ab");
		send_text("{abcd");
		send_text("$HEX[00]");
		finish_lines();
	endtask

	task automatic test_prefix_parsing();
		write_reg(lwjf_pkg::REG_WEIGHTED_MODE, 1'b1);
		write_reg(lwjf_pkg::REG_JUNK_FILTER, 1'b0);
		send_text("3:abc");
		send_text("0:abc");
		send_text("000:z");
		send_text("4294967295:x");
		send_text("4294967296:x");
		send_text("7:");
		send_text(":abc");
		send_text("12345");
		send_text("12a:b");
		finish_lines();
	endtask

	task automatic test_junk_rules();
		write_reg(lwjf_pkg::REG_JUNK_FILTER, 1'b1);
		send_text("{\"k\":1}");
		send_text("[1,2]");
		send_text("{ab");
		send_text("<div>");
		send_text("</p>");
		send_text("<!--");
		send_text("<1ab");
		text_buf.delete();
		add_from(HEX_SET, 32);
		send_buf();
		text_buf.delete();
		add_from(HEX_SET, 31);
		send_buf();
		text_buf.delete();
		text_buf.push_back("8");
		text_buf.push_back(":");
		add_from(HEX_SET, 32);
		send_buf();
		text_buf.delete();
		add_from(B64_SET, 39);
		text_buf.push_back("=");
		send_buf();
		text_buf.delete();
		add_from(B64_SET, 38);
		text_buf.push_back("=");
		text_buf.push_back("A");
		send_buf();
		text_buf.delete();
		add_from(B64_SET, 38);
		text_buf.push_back("=");
		send_buf();
		finish_lines();
	endtask

	// The hex wrapper is flagged with the junk checks off as well.
	task automatic test_hex_wrap();
		write_reg(lwjf_pkg::REG_JUNK_FILTER, 1'b0);
		send_text("$HEX[41]");
		send_text("$HEX[");
		send_text("$HEX");
		send_text("5:$HEX[4142]");
		send_text("$HEx[41]");
		finish_lines();
	endtask

	// A prefixed line past the length limit and one byte past the counter's
	// saturation point.
	task automatic test_line_length();
		set_idling(2);
		text_buf.delete();
		text_buf.push_back("5");
		text_buf.push_back(":");
		add_noise(LINE_CAP - 1);
		send_buf();
		finish_lines();
	endtask

	// Random lines over all four register settings and all idling patterns.
	task automatic test_random_mix();
		int phase;
		int sent_at;
		for (phase = 0; phase < 6; phase++) begin
			set_idling(phase / 2);
			write_reg(lwjf_pkg::REG_WEIGHTED_MODE, MIX_WEIGHTED[phase]);
			write_reg(lwjf_pkg::REG_JUNK_FILTER, MIX_JUNK[phase]);
			sent_at = bytes_sent;
			while (bytes_sent - sent_at < MIX_BYTES) begin
				build_random_line();
				send_buf();
			end
			finish_lines();
		end
	endtask

	initial begin
		weighted_on = 1'b0;
		junk_on     = 1'b0;
		clear_line();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_settings();
		test_prefix_parsing();
		test_junk_rules();
		test_hex_wrap();
		test_line_length();
		test_random_mix();

		$display("Sent %0d line bytes, checked %0d verdicts.", bytes_sent, verdicts_seen);
		$display("Covered prefixes, junk rules, hex wrapper, long lines and all idling patterns.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
